FILE: hdl/psb_pkg.sv
// psb_pkg: shared constants, field widths and the controller/datapath
// command and status structs of the palette shade table builder.
// No dependencies.
package psb_pkg;

  // palette geometry
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = 8;
  localparam int CNT_W       = 9;
  localparam int COL_W       = 8;
  localparam int RGB_W       = 3 * COL_W;

  // shade levels
  localparam int LVL_W      = 6;
  localparam logic [LVL_W-1:0] LVL_LAST = '1;

  // arithmetic
  localparam logic [LVL_W-1:0] SHADE_TOP   = 6'd63;
  localparam logic [4:0]       SHADE_ROUND = 5'd16;
  localparam int               SHADE_SHIFT = 5;
  localparam int               SQ_W        = 2 * COL_W;
  localparam int               DIST_W      = SQ_W + 2;

  // register reset
  localparam logic [CNT_W-1:0] FB_RESET = 9'd32;

  // stream widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // command codes carried on the input tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_GEN   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic pal_wr;     // write the palette entry from the input beat
    logic src_rd;     // read the source entry named by the input beat
    logic src_lat;    // latch source colour and fullbright flag, clear level
    logic scale_lat;  // register the scaled colour, clear the entry counter
    logic issue;      // read the next palette entry for the search
    logic res_load;   // load the output register
    logic level_inc;  // step to the next shade level
  } psb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fullbright;
    logic issue_last;
    logic pipe_busy;
    logic level_last;
  } psb_stat_t;

endpackage

FILE: hdl/psb_ram.sv
// psb_ram: generic single-port RAM with registered read.
// No dependencies.
module psb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/psb_dp.sv
// psb_dp: datapath of the shade table builder: palette RAM, shade scaling,
// the nearest-colour search pipeline and the output register.
// Depends on psb_pkg and psb_ram.
module psb_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  psb_pkg::psb_cmd_t                 cmd,
  output psb_pkg::psb_stat_t                stat,
  input  logic [psb_pkg::IN_DATA_W-1:0]     in_data,
  input  logic                              cfg_we,
  input  logic [psb_pkg::CNT_W-1:0]         cfg_wdata,
  output logic [psb_pkg::LVL_W-1:0]         res_level,
  output logic [psb_pkg::PAL_AW-1:0]        res_index,
  output logic                              res_last
);
  import psb_pkg::*;

  localparam logic [PAL_AW-1:0] ENTRY_LAST = PAL_AW'(PAL_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  ENTRIES_C  = CNT_W'(PAL_ENTRIES);

  logic [PAL_AW-1:0] in_idx;
  logic [RGB_W-1:0]  in_rgb;
  logic              in_range;
  logic              ram_we;
  logic [PAL_AW-1:0] ram_addr;
  logic [RGB_W-1:0]  ram_rdata;

  logic [CNT_W-1:0]  fb_count;
  logic [CNT_W-1:0]  threshold;
  logic [PAL_AW-1:0] src_idx;
  logic [PAL_AW-1:0] src_idx_q;
  logic [COL_W-1:0]  src_r, src_g, src_b;
  logic              fullbright;
  logic [LVL_W-1:0]  level;
  logic [COL_W-1:0]  scl_r, scl_g, scl_b;
  logic [COL_W-1:0]  scl_r_next, scl_g_next, scl_b_next;

  logic [PAL_AW-1:0] entry_cnt;
  logic              v1, v2;
  logic [PAL_AW-1:0] idx1, idx2;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  logic [DIST_W-1:0] sum_sq;
  logic [DIST_W-1:0] min_sq;
  logic [PAL_AW-1:0] best_idx;

  // input beat fields: entry_index, red, green, blue from the lowest bit up
  assign in_idx   = in_data[PAL_AW-1:0];
  assign in_rgb   = in_data[PAL_AW +: RGB_W];
  assign in_range = {1'b0, in_idx} < ENTRIES_C;

  // palette port: beat address for writes and source reads, else the sweep
  assign ram_we   = cmd.pal_wr && in_range;
  assign ram_addr = (cmd.pal_wr || cmd.src_rd) ? in_idx : entry_cnt;

  psb_ram #(
    .WIDTH(RGB_W),
    .DEPTH(PAL_ENTRIES)
  ) u_pal (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_rgb),
    .rdata(ram_rdata)
  );

  // fullbright count register
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_count <= FB_RESET;
    end else if (cfg_we) begin
      fb_count <= cfg_wdata;
    end
  end

  assign threshold = (fb_count >= ENTRIES_C) ? '0 : ENTRIES_C - fb_count;

  // source capture
  always_ff @(posedge clk) begin
    if (cmd.src_rd) begin
      src_idx_q <= in_idx;
    end
    if (cmd.src_lat) begin
      src_r      <= ram_rdata[COL_W-1:0];
      src_g      <= ram_rdata[COL_W +: COL_W];
      src_b      <= ram_rdata[2*COL_W +: COL_W];
      fullbright <= {1'b0, src_idx_q} >= threshold;
    end
  end
  assign src_idx = src_idx_q;

  // shade level counter
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cmd.src_lat) begin
      level <= '0;
    end else if (cmd.level_inc) begin
      level <= level + LVL_W'(1);
    end
  end

  // scale one channel by (63 - level), round, shift and clamp
  function automatic logic [COL_W-1:0] shade_ch(input logic [COL_W-1:0] c,
                                                 input logic [LVL_W-1:0] lvl);
    logic [COL_W+LVL_W-1:0]  prod;
    logic [COL_W+LVL_W:0]    sum;
    logic [COL_W+LVL_W-SHADE_SHIFT:0] v;
    prod = (COL_W+LVL_W)'(c) * (COL_W+LVL_W)'(SHADE_TOP - lvl);
    sum  = {1'b0, prod} + (COL_W+LVL_W+1)'(SHADE_ROUND);
    v    = sum[COL_W+LVL_W:SHADE_SHIFT];
    return (v > (COL_W+LVL_W-SHADE_SHIFT+1)'(255)) ? '1 : v[COL_W-1:0];
  endfunction

  assign scl_r_next = shade_ch(src_r, level);
  assign scl_g_next = shade_ch(src_g, level);
  assign scl_b_next = shade_ch(src_b, level);

  always_ff @(posedge clk) begin
    if (cmd.scale_lat) begin
      scl_r <= scl_r_next;
      scl_g <= scl_g_next;
      scl_b <= scl_b_next;
    end
  end

  // squared channel distance
  function automatic logic [SQ_W-1:0] diff_sq(input logic [COL_W-1:0] a,
                                               input logic [COL_W-1:0] b);
    logic [COL_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // sweep address counter
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_cnt <= '0;
    end else if (cmd.scale_lat) begin
      entry_cnt <= '0;
    end else if (cmd.issue) begin
      entry_cnt <= entry_cnt + PAL_AW'(1);
    end
  end

  // search pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  // squares stage on the palette read data
  always_ff @(posedge clk) begin
    idx1 <= entry_cnt;
    idx2 <= idx1;
    sq_r <= diff_sq(scl_r, ram_rdata[COL_W-1:0]);
    sq_g <= diff_sq(scl_g, ram_rdata[COL_W +: COL_W]);
    sq_b <= diff_sq(scl_b, ram_rdata[2*COL_W +: COL_W]);
  end

  assign sum_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  // running minimum, lowest index kept on a tie
  always_ff @(posedge clk) begin
    if (v2 && (idx2 == '0 || sum_sq < min_sq)) begin
      min_sq   <= sum_sq;
      best_idx <= idx2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_level <= level;
      res_index <= fullbright ? src_idx : best_idx;
      res_last  <= level == LVL_LAST;
    end
  end

  assign stat.fullbright = fullbright;
  assign stat.issue_last = entry_cnt == ENTRY_LAST;
  assign stat.pipe_busy  = v1 || v2;
  assign stat.level_last = level == LVL_LAST;

  // checks
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("search stage two without stage one");

  a_fb_self: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load && fullbright |=> res_index == src_idx)
    else $error("fullbright colour not mapped to itself");

  a_no_fb_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !fullbright)
    else $error("palette search started for a fullbright colour");

endmodule

FILE: hdl/psb_ctrl.sv
// psb_ctrl: controller state machine of the shade table builder; sequences
// palette writes, source reads, per-level scale, sweep and result beats.
// Depends on psb_pkg.
module psb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output psb_pkg::psb_cmd_t  cmd,
  input  psb_pkg::psb_stat_t stat
);
  import psb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRC   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_GEN) begin
            cmd.src_rd = 1'b1;
            state_next = S_SRC;
          end else begin
            cmd.pal_wr = 1'b1;
          end
        end
      end
      S_SRC: begin
        cmd.src_lat = 1'b1;
        state_next  = S_SCALE;
      end
      S_SCALE: begin
        if (stat.fullbright) begin
          cmd.res_load = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.scale_lat = 1'b1;
          state_next    = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.level_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.level_inc = 1'b1;
            state_next    = S_SCALE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && stat.level_last |=> in_ready)
    else $error("not idle after the last shade beat");

  a_load_then_show: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> out_valid)
    else $error("result loaded but not presented");

endmodule

FILE: hdl/palette_shade_table_builder_top.sv
// Palette shade table builder, top level: stream ports, config register
// port, controller and datapath. Depends on psb_pkg, psb_ctrl, psb_dp.
//
// Load the palette with write beats (tuser 0, one entry per beat), then
// send a generate beat (tuser 1) naming a source colour; the block
// returns 64 beats, shade levels 0 to 63, the last with tlast.
// Every entry must have been written before a generate beat. A colour in
// the fullbright range (index at or above 256 minus fullbright_count) maps
// to itself. Any other colour takes, per shade, a scale step, a scan of
// the palette through the single RAM read port, a drain of the search
// pipeline and an output step. The input is accepted only while no
// generate run is in progress.
// cfg_we may be raised only while the block is idle.
module palette_shade_table_builder_top (
  input  logic                          clk,
  input  logic                          rst,
  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [psb_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // command[0]
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // shade_level[5:0], mapped_index[13:6], zero fill[15:14]
  output logic [psb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we,
  input  logic [psb_pkg::CNT_W-1:0]     cfg_wdata
);
  import psb_pkg::*;

  psb_cmd_t          cmd;
  psb_stat_t         stat;
  logic [LVL_W-1:0]  res_level;
  logic [PAL_AW-1:0] res_index;

  // sequencing
  psb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // storage and arithmetic
  psb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .res_level(res_level),
    .res_index(res_index),
    .res_last (m_axis_tlast)
  );

  // output beat packing
  assign m_axis_tdata = {(OUT_DATA_W - LVL_W - PAL_AW)'(0), res_index, res_level};

endmodule
